FILE: src/rlpe_pkg.sv
// Shared types and constants for the RGB LED chain pulse encoder.
`default_nettype none

package rlpe_pkg;

    localparam int MAX_LEDS     = 64;
    localparam int LED_AW       = $clog2(MAX_LEDS);
    localparam int BITS_PER_LED = 24;
    localparam int COLOR_W      = 24;
    localparam int COLOR_IW     = $clog2(COLOR_W);
    localparam int MAX_PAD      = 2;
    localparam int PAD_W        = 2;
    localparam int COUNT_W      = 7;
    localparam int TICK_W       = 16;
    localparam int SLOT_W       = $clog2(BITS_PER_LED + MAX_PAD + 1);
    localparam int Q_DEPTH      = 2;
    localparam int Q_CW         = $clog2(Q_DEPTH + 1);
    localparam int Q_PW         = $clog2(Q_DEPTH);

    // Configuration register indexes.
    localparam logic [1:0] REG_ONE_TICKS  = 2'd0;
    localparam logic [1:0] REG_ZERO_TICKS = 2'd1;
    localparam logic [1:0] REG_LEDS       = 2'd2;
    localparam logic [1:0] REG_PADS       = 2'd3;

    // Item kinds carried on s_tuser.
    localparam logic MODE_SET  = 1'b0;
    localparam logic MODE_EMIT = 1'b1;

    typedef struct packed {
        logic [TICK_W-1:0]  one_ticks;
        logic [TICK_W-1:0]  zero_ticks;
        logic [COUNT_W-1:0] leds_in_use;
        logic [PAD_W-1:0]   pad_words;
    } cfg_t;

    // One emit job: the LED colour and the padding that follows it.
    typedef struct packed {
        logic [COLOR_W-1:0] color;
        logic               closes;
        logic [PAD_W-1:0]   pads;
    } job_t;

    typedef struct packed {
        logic empty;
        logic full;
    } q_stat_t;

endpackage

`default_nettype wire

FILE: src/rlpe_front.sv
// Front end: takes input beats, keeps the frame store and turns emits into jobs.
`default_nettype none

module rlpe_front (
    input  wire logic                          aclk,
    input  wire logic                          aresetn,
    input  wire logic                          s_tvalid,
    output logic                               s_tready,
    input  wire logic [31:0]                   s_tdata,
    input  wire logic                          s_tuser,
    input  wire rlpe_pkg::cfg_t                cfg,
    input  wire rlpe_pkg::q_stat_t             q_stat,
    output logic                               push,
    output rlpe_pkg::job_t                     push_job
);

    logic [rlpe_pkg::COLOR_W-1:0]  store_mem [rlpe_pkg::MAX_LEDS];
    logic [rlpe_pkg::MAX_LEDS-1:0] valid_reg;
    logic [rlpe_pkg::LED_AW-1:0]   pos_reg;
    logic [rlpe_pkg::COLOR_W-1:0]  rd_data_reg;
    logic                          rd_valid_reg;
    logic                          pend_reg;
    logic                          pend_closes_reg;
    logic [rlpe_pkg::PAD_W-1:0]    pend_pads_reg;

    logic                          acc;
    logic                          acc_set;
    logic                          acc_emit;
    logic [rlpe_pkg::LED_AW-1:0]   led_index;
    logic [rlpe_pkg::COLOR_W-1:0]  color_in;
    logic [rlpe_pkg::COUNT_W-1:0]  count;
    logic [rlpe_pkg::COUNT_W-1:0]  pos_plus1;
    logic                          closes;
    logic [rlpe_pkg::PAD_W-1:0]    pads_clamped;

    assign s_tready  = !pend_reg && !q_stat.full;
    assign acc       = s_tvalid && s_tready;
    assign acc_set   = acc && (s_tuser == rlpe_pkg::MODE_SET);
    assign acc_emit  = acc && (s_tuser == rlpe_pkg::MODE_EMIT);
    assign led_index = s_tdata[5:0];
    // Stored green, red, blue from the top bit down.
    assign color_in  = {s_tdata[21:14], s_tdata[13:6], s_tdata[29:22]};

    always_comb begin
        if (cfg.leds_in_use == '0) begin
            count = rlpe_pkg::COUNT_W'(1);
        end else if (cfg.leds_in_use > rlpe_pkg::COUNT_W'(rlpe_pkg::MAX_LEDS)) begin
            count = rlpe_pkg::COUNT_W'(rlpe_pkg::MAX_LEDS);
        end else begin
            count = cfg.leds_in_use;
        end
        if (cfg.pad_words > rlpe_pkg::PAD_W'(rlpe_pkg::MAX_PAD)) begin
            pads_clamped = rlpe_pkg::PAD_W'(rlpe_pkg::MAX_PAD);
        end else begin
            pads_clamped = cfg.pad_words;
        end
        pos_plus1 = rlpe_pkg::COUNT_W'(pos_reg) + rlpe_pkg::COUNT_W'(1);
        closes    = pos_plus1 >= count;
    end

    // Frame store: a set beat writes one entry and an emit beat does one registered read.
    always_ff @(posedge aclk) begin
        if (acc_set) begin
            store_mem[led_index] <= color_in;
        end
        if (acc_emit) begin
            rd_data_reg <= store_mem[pos_reg];
        end
    end

    // Entries never written since reset read as black.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (acc_set) begin
            valid_reg[led_index] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pos_reg  <= '0;
            pend_reg <= 1'b0;
        end else begin
            pend_reg <= acc_emit;
            if (acc_emit) begin
                pos_reg <= closes ? '0 : pos_plus1[rlpe_pkg::LED_AW-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (acc_emit) begin
            rd_valid_reg    <= valid_reg[pos_reg];
            pend_closes_reg <= closes;
            pend_pads_reg   <= closes ? pads_clamped : '0;
        end
    end

    assign push            = pend_reg;
    assign push_job.color  = rd_valid_reg ? rd_data_reg : '0;
    assign push_job.closes = pend_closes_reg;
    assign push_job.pads   = pend_pads_reg;

    a_push_has_room: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg |-> !q_stat.full)
        else $error("job pushed into a full queue");

    a_wrap_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_emit && closes) |=> (pos_reg == '0))
        else $error("position did not wrap after the closing LED");

    a_pads_only_on_close: assert property (@(posedge aclk) disable iff (!aresetn)
        (pend_reg && !pend_closes_reg) |-> (pend_pads_reg == '0))
        else $error("padding queued for a run that does not close the frame");

endmodule

`default_nettype wire

FILE: src/rlpe_queue.sv
// Two-entry job queue between the front end and the pulse generator.
`default_nettype none

module rlpe_queue (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              push,
    input  wire rlpe_pkg::job_t    push_job,
    input  wire logic              pop,
    output rlpe_pkg::job_t         head,
    output rlpe_pkg::q_stat_t      stat
);

    rlpe_pkg::job_t             slot_mem [rlpe_pkg::Q_DEPTH];
    logic [rlpe_pkg::Q_PW-1:0]  wr_ptr_reg;
    logic [rlpe_pkg::Q_PW-1:0]  rd_ptr_reg;
    logic [rlpe_pkg::Q_CW-1:0]  count_reg;

    assign stat.empty = (count_reg == '0);
    assign stat.full  = (count_reg == rlpe_pkg::Q_CW'(rlpe_pkg::Q_DEPTH));
    assign head       = slot_mem[rd_ptr_reg];

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(push && stat.full))
        else $error("push into a full job queue");

    a_no_underflow: assert property (@(posedge aclk) disable iff (!aresetn)
        !(pop && stat.empty))
        else $error("pop from an empty job queue");

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= rlpe_pkg::Q_CW'(rlpe_pkg::Q_DEPTH))
        else $error("job queue count out of range");

endmodule

`default_nettype wire

FILE: src/rlpe_back.sv
// Pulse generator: walks the queue head one compare word per cycle while m_tready does not stall it.
`default_nettype none

module rlpe_back (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire rlpe_pkg::cfg_t                 cfg,
    input  wire rlpe_pkg::job_t                 head,
    input  wire rlpe_pkg::q_stat_t              q_stat,
    output logic                                pop,
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [rlpe_pkg::TICK_W-1:0]         m_tdata,
    output logic                                m_tlast,
    output logic                                m_tuser
);

    localparam logic [rlpe_pkg::SLOT_W-1:0] BIT_SLOTS = rlpe_pkg::SLOT_W'(rlpe_pkg::BITS_PER_LED);

    logic [rlpe_pkg::SLOT_W-1:0] slot_reg;
    logic                        m_tvalid_reg;
    logic [rlpe_pkg::TICK_W-1:0] m_tdata_reg;
    logic                        m_tlast_reg;
    logic                        m_tuser_reg;

    logic                        adv;
    logic [rlpe_pkg::SLOT_W-1:0] total_slots;
    logic                        last_slot;
    logic [rlpe_pkg::SLOT_W-1:0] bit_idx;
    logic                        in_bits;
    logic                        bit_val;
    logic [rlpe_pkg::TICK_W-1:0] word_next;

    assign adv         = !q_stat.empty && (!m_tvalid_reg || m_tready);
    assign total_slots = BIT_SLOTS + rlpe_pkg::SLOT_W'(head.pads);
    assign last_slot   = (slot_reg == total_slots - 1'b1);
    assign pop         = adv && last_slot;

    always_comb begin
        in_bits = slot_reg < BIT_SLOTS;
        bit_idx = BIT_SLOTS - 1'b1 - slot_reg;
        // Leading bits beyond the colour word go out as zero bits.
        bit_val = (bit_idx < rlpe_pkg::SLOT_W'(rlpe_pkg::COLOR_W))
                  && head.color[bit_idx[rlpe_pkg::COLOR_IW-1:0]];
        if (!in_bits) begin
            word_next = '0;
        end else if (bit_val) begin
            word_next = cfg.one_ticks;
        end else begin
            word_next = cfg.zero_ticks;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            slot_reg     <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (adv) begin
                m_tvalid_reg <= 1'b1;
                slot_reg     <= last_slot ? '0 : slot_reg + 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            m_tdata_reg <= word_next;
            m_tlast_reg <= last_slot;
            m_tuser_reg <= head.closes;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tlast  = m_tlast_reg;
    assign m_tuser  = m_tuser_reg;

    a_slot_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        slot_reg <= BIT_SLOTS + rlpe_pkg::SLOT_W'(rlpe_pkg::MAX_PAD))
        else $error("slot counter out of range");

    a_restart_after_last: assert property (@(posedge aclk) disable iff (!aresetn)
        pop |=> (slot_reg == '0))
        else $error("slot counter did not restart after the final word");

    a_idle_holds_slot: assert property (@(posedge aclk) disable iff (!aresetn)
        q_stat.empty |-> (slot_reg == '0))
        else $error("slot counter moved without a job");

endmodule

`default_nettype wire

FILE: src/rgb_led_chain_pulse_encoder_unit.sv
// Top level of the RGB LED chain pulse encoder: configuration registers and wiring.
`default_nettype none

// A set beat (s_tuser = 0) writes one LED's colour into a 64-entry frame store
// and returns nothing. An emit beat (s_tuser = 1) reads the LED at the
// current send position and returns 24 timer compare words, green, red, blue,
// most significant bit first; on the last LED in use up to two zero padding words
// follow and every word of that run carries the frame-end flag on m_tuser.
// The pulse generator gives one word per cycle straight from the job queue while
// m_tready does not stall it, so consecutive emits run without gaps; the first word
// goes through the front end's registered frame-store read, the job queue and the
// pulse generator's output register. The front end takes no new beat while an
// emit's frame-store read is pending. The job queue holds the emit being sent and
// one more waiting; while it is full no beat, set or emit, is accepted. The frame
// store needs no clearing pass after reset: unwritten LEDs read as black.
module rgb_led_chain_pulse_encoder_unit (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [31:0] s_tdata,   // led_index[5:0], red[13:6], green[21:14], blue[29:22]
    input  wire logic        s_tuser,   // mode[0]
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // compare_value[15:0]
    output logic             m_tlast,
    output logic             m_tuser,   // frame_end[0]
    input  wire logic        cfg_we,
    input  wire logic [1:0]  cfg_index,
    input  wire logic [15:0] cfg_wdata
);

    rlpe_pkg::cfg_t    cfg_reg;
    rlpe_pkg::job_t    push_job;
    rlpe_pkg::job_t    head;
    rlpe_pkg::q_stat_t q_stat;
    logic              push;
    logic              pop;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.one_ticks   <= rlpe_pkg::TICK_W'(12);
            cfg_reg.zero_ticks  <= rlpe_pkg::TICK_W'(6);
            cfg_reg.leds_in_use <= rlpe_pkg::COUNT_W'(rlpe_pkg::MAX_LEDS);
            cfg_reg.pad_words   <= rlpe_pkg::PAD_W'(rlpe_pkg::MAX_PAD);
        end else if (cfg_we) begin
            unique case (cfg_index)
                rlpe_pkg::REG_ONE_TICKS:  cfg_reg.one_ticks   <= cfg_wdata;
                rlpe_pkg::REG_ZERO_TICKS: cfg_reg.zero_ticks  <= cfg_wdata;
                rlpe_pkg::REG_LEDS:       cfg_reg.leds_in_use <= cfg_wdata[rlpe_pkg::COUNT_W-1:0];
                rlpe_pkg::REG_PADS:       cfg_reg.pad_words   <= cfg_wdata[rlpe_pkg::PAD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    rlpe_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .cfg      (cfg_reg),
        .q_stat   (q_stat),
        .push     (push),
        .push_job (push_job)
    );

    rlpe_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .push     (push),
        .push_job (push_job),
        .pop      (pop),
        .head     (head),
        .stat     (q_stat)
    );

    rlpe_back u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .cfg      (cfg_reg),
        .head     (head),
        .q_stat   (q_stat),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast),
        .m_tuser  (m_tuser)
    );

endmodule

`default_nettype wire
